/* hw/rtl/necir_pkg.sv */
// Shared types and constants of the NEC extended frame slot encoder.
package necir_pkg;

	localparam int unsigned PAIR_CNT_W = 6;
	localparam int unsigned DATA_BITS = 32;

	localparam logic [PAIR_CNT_W-1:0] HDR_IDX = 6'd0;
	localparam logic [PAIR_CNT_W-1:0] STOP_IDX = 6'd33;

	localparam logic [4:0] HDR_MARK = 5'd16;
	localparam logic [4:0] UNIT_MARK = 5'd1;
	localparam logic [3:0] HDR_SPACE = 4'd8;
	localparam logic [3:0] ONE_SPACE = 4'd3;
	localparam logic [3:0] UNIT_SPACE = 4'd1;

	typedef struct packed {
		logic [7:0] address_low;
		logic [7:0] address_high;
		logic [7:0] command;
	} req_t;

	typedef struct packed {
		logic [4:0] mark_slots;
		logic [3:0] space_slots;
		logic [5:0] pair_index;
		logic last_pair;
	} pair_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic slot_free;
		logic at_stop;
	} stat_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN = 2'b10
	} state_t;

endpackage

/* hw/rtl/necir_ctrl.sv */
// Controller state machine of the NEC extended frame slot encoder.
module necir_ctrl (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input necir_pkg::stat_t stat,
	output necir_pkg::cmd_t cmd,
	output logic busy
);

	necir_pkg::state_t state_q;
	necir_pkg::state_t state_d;
	logic running;
	logic finishing;
	logic can_take;

	assign running = (state_q == necir_pkg::ST_RUN);
	assign finishing = running && stat.slot_free && stat.at_stop;
	// A new frame may enter in the cycle that the stop pair is loaded.
	assign can_take = (state_q == necir_pkg::ST_IDLE) || finishing;

	assign req_stall = !can_take;
	assign cmd.load = req_valid && can_take;
	assign cmd.emit = running && stat.slot_free;
	assign busy = running;

	always_comb begin
		state_d = state_q;
		case (state_q)
			necir_pkg::ST_IDLE: begin
				if (cmd.load) begin
					state_d = necir_pkg::ST_RUN;
				end
			end
			necir_pkg::ST_RUN: begin
				if (finishing && !cmd.load) begin
					state_d = necir_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = necir_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= necir_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hw/rtl/necir_dp.sv */
// Datapath of the NEC extended frame slot encoder: data shifter, pair counter, output register.
module necir_dp (
	input logic clk,
	input logic arst_n,
	input necir_pkg::req_t req,
	input necir_pkg::cmd_t cmd,
	output necir_pkg::stat_t stat,
	output logic pair_valid,
	input logic pair_stall,
	output necir_pkg::pair_t pair
);

	logic [necir_pkg::DATA_BITS-1:0] shift_q;
	logic [necir_pkg::PAIR_CNT_W-1:0] cnt_q;
	logic out_valid_q;
	necir_pkg::pair_t out_q;
	necir_pkg::pair_t next_pair;

	assign stat.slot_free = !out_valid_q || !pair_stall;
	assign stat.at_stop = (cnt_q == necir_pkg::STOP_IDX);

	always_comb begin
		next_pair.pair_index = cnt_q;
		next_pair.mark_slots = necir_pkg::UNIT_MARK;
		next_pair.space_slots = shift_q[0] ? necir_pkg::ONE_SPACE : necir_pkg::UNIT_SPACE;
		next_pair.last_pair = 1'b0;
		if (cnt_q == necir_pkg::HDR_IDX) begin
			next_pair.mark_slots = necir_pkg::HDR_MARK;
			next_pair.space_slots = necir_pkg::HDR_SPACE;
		end else if (cnt_q == necir_pkg::STOP_IDX) begin
			next_pair.space_slots = necir_pkg::UNIT_SPACE;
			next_pair.last_pair = 1'b1;
		end
	end

	// The shifter and counter hold no control meaning before a load.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			shift_q <= {~req.command, req.command, req.address_high, req.address_low};
			cnt_q <= necir_pkg::HDR_IDX;
		end else if (cmd.emit) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q != necir_pkg::HDR_IDX) begin
				shift_q <= {1'b0, shift_q[necir_pkg::DATA_BITS-1:1]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!pair_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= next_pair;
		end
	end

	assign pair_valid = out_valid_q;
	assign pair = out_q;

endmodule

/* hw/rtl/nec_ir_frame_slot_encoder.sv */
// Top level of the NEC extended infrared frame encoder in slot run-length form.

// Each accepted item is one frame request (address low byte, address high byte,
// command byte). The block answers with 34 result items, each one mark/space pair
// counted in 562.5 us slots: a header of 16 mark and 8 space slots, then 32 data
// bits LSB first (address low, address high, command, inverted command), each a
// 1-slot mark with a 3-slot space for a one or a 1-slot space for a zero, and
// finally a stop pair of 1 and 1 slots that carries last_pair. The pair counter
// in the datapath steps once per cycle through the pairs while the output is not
// stalled, and loads each into the output register. A new request is taken in
// the same cycle that the stop pair is loaded, so frames can follow each other
// with no gap, while the stop pair may still wait to be taken. Output stalls
// simply hold the counter; no pair is lost or repeated.
module nec_ir_frame_slot_encoder (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input necir_pkg::req_t req,
	output logic pair_valid,
	input logic pair_stall,
	output necir_pkg::pair_t pair
);

	necir_pkg::cmd_t cmd;
	necir_pkg::stat_t stat;
	logic busy;

	// The controller decides when to take a request and when to emit a pair.
	necir_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.stat(stat),
		.cmd(cmd),
		.busy(busy)
	);

	// The datapath holds the 32 frame bits, the pair counter and the output register.
	necir_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.cmd(cmd),
		.stat(stat),
		.pair_valid(pair_valid),
		.pair_stall(pair_stall),
		.pair(pair)
	);

	// Only the stop pair may close a frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pair_valid && pair.last_pair) |-> (pair.pair_index == necir_pkg::STOP_IDX))
		else $error("last_pair set on a pair other than the stop pair");

	// The header pair always carries the long mark and space.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pair_valid && pair.pair_index == necir_pkg::HDR_IDX) |->
		(pair.mark_slots == necir_pkg::HDR_MARK &&
		pair.space_slots == necir_pkg::HDR_SPACE))
		else $error("header pair has wrong slot counts");

	// Once a request is taken, the encoder is busy and refuses the next one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (busy && req_stall))
		else $error("encoder not busy after taking a request");

	// A taken request always leaves a pair on the output: in the cycle after the
	// request, the header is loaded unless a stalled pair still waits to be taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> ##1 pair_valid)
		else $error("no pair on the output after taking a request");

endmodule
